[design/mexp_pkg.sv]
// Shared constants, types and the control store for the modular exponentiation block.
package mexp_pkg;

    localparam int WORD_WIDTH_DEF = 32;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS  = 1'b1;

    localparam int EXPONENT_RESET = 29;
    localparam int MODULUS_RESET  = 91;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED,
        OP_INIT,
        OP_SQ_START,
        OP_DBL,
        OP_ADD,
        OP_ACC_LOAD,
        OP_EXP_NEXT,
        OP_BASE_START,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_ITEM,
        C_TRIVIAL,
        C_RED_MORE,
        C_DBL_SKIP,
        C_MUL_MORE,
        C_BASE_MUL,
        C_EXP_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t S_WAIT = 4'd0;
    localparam step_t S_TRIV = 4'd1;
    localparam step_t S_RED  = 4'd2;
    localparam step_t S_INIT = 4'd3;
    localparam step_t S_SQ   = 4'd4;
    localparam step_t S_DBL  = 4'd5;
    localparam step_t S_ADD  = 4'd6;
    localparam step_t S_ACC  = 4'd7;
    localparam step_t S_EXP  = 4'd8;
    localparam step_t S_OUT  = 4'd9;
    localparam step_t S_BASE = 4'd10;

    // One control word: datapath operation, jump condition, jump target and
    // the step taken when the condition is false.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;
        step_t fall;
    } ctrl_t;

    function automatic ctrl_t ucode(step_t pc);
        ctrl_t w;
        case (pc)
            S_WAIT:  w = '{OP_LOAD,       C_NO_ITEM,  S_WAIT, S_TRIV};
            S_TRIV:  w = '{OP_NONE,       C_TRIVIAL,  S_OUT,  S_RED};
            S_RED:   w = '{OP_RED,        C_RED_MORE, S_RED,  S_INIT};
            S_INIT:  w = '{OP_INIT,       C_ALWAYS,   S_SQ,   S_SQ};
            S_SQ:    w = '{OP_SQ_START,   C_ALWAYS,   S_DBL,  S_DBL};
            S_DBL:   w = '{OP_DBL,        C_DBL_SKIP, S_DBL,  S_ADD};
            S_ADD:   w = '{OP_ADD,        C_MUL_MORE, S_DBL,  S_ACC};
            S_ACC:   w = '{OP_ACC_LOAD,   C_BASE_MUL, S_BASE, S_EXP};
            S_EXP:   w = '{OP_EXP_NEXT,   C_EXP_MORE, S_SQ,   S_OUT};
            S_OUT:   w = '{OP_OUT,        C_OUT_BUSY, S_OUT,  S_WAIT};
            S_BASE:  w = '{OP_BASE_START, C_ALWAYS,   S_DBL,  S_DBL};
            default: w = '{OP_NONE,       C_ALWAYS,   S_WAIT, S_WAIT};
        endcase
        return w;
    endfunction

endpackage

[design/mexp_if.sv]
// Valid/ready channel interfaces for message items and result items.
interface mexp_msg_if #(parameter int WORD_WIDTH = mexp_pkg::WORD_WIDTH_DEF);
    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] message;

    modport source (output valid, output message, input ready);
    modport sink   (input valid, input message, output ready);
endinterface

interface mexp_res_if #(parameter int WORD_WIDTH = mexp_pkg::WORD_WIDTH_DEF);
    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

[design/modular_exponentiation.sv]
// Top level: microcoded square-and-multiply modular exponentiation.
//
//   channel    dir  handshake          payload
//   request    in   valid/ready        message
//   response   out  valid/ready        power_result
//   config     in   cfg_write          cfg_index, cfg_data (exponent, modulus)
//
// One item at a time. Zero exponent or modulus below two: from the trivial check
// straight to the output register. Otherwise the message is reduced first, then
// per exponent bit a squaring, a multiply by the base when the bit is set and a
// shift step. Each multiply runs a start step, W doublings, one add per set bit
// plus one when the last bit is clear, and a product load. Reset clears the
// sequencer and loads the key defaults; a result held in the output register
// lets the next item in.
module modular_exponentiation #(
    parameter int WORD_WIDTH = mexp_pkg::WORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mexp_msg_if.sink                         request,
    mexp_res_if.source                       response,
    input  logic                             cfg_write,
    input  logic [mexp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_WIDTH-1:0]            cfg_data
);

    localparam int CNT_W = $clog2(WORD_WIDTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WORD_WIDTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [WORD_WIDTH-1:0] exp_reg, exp_next;
    logic [WORD_WIDTH-1:0] mod_reg, mod_next;

    mexp_pkg::step_t pc_reg, pc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      ecnt_reg, ecnt_next;
    logic                  phase_reg, phase_next;
    logic                  addf_reg, addf_next;
    logic                  out_valid_reg, out_valid_next;

    logic [WORD_WIDTH-1:0] sh_reg, sh_next;
    logic [WORD_WIDTH-1:0] esh_reg, esh_next;
    logic [WORD_WIDTH-1:0] p_reg, p_next;
    logic [WORD_WIDTH-1:0] a_reg, a_next;
    logic [WORD_WIDTH-1:0] base_reg, base_next;
    logic [WORD_WIDTH-1:0] acc_reg, acc_next;
    logic [WORD_WIDTH-1:0] out_data_reg, out_data_next;

    mexp_pkg::ctrl_t       ctrl;
    logic                  in_accept;
    logic                  out_free;
    logic                  take;

    logic [WORD_WIDTH:0]   cand;
    logic [WORD_WIDTH+1:0] diff;
    logic [WORD_WIDTH-1:0] reduced;

    assign ctrl      = mexp_pkg::ucode(pc_reg);
    assign in_accept = request.valid && request.ready;
    assign out_free  = !out_valid_reg || response.ready;

    assign request.ready         = (pc_reg == mexp_pkg::S_WAIT);
    assign response.valid        = out_valid_reg;
    assign response.power_result = out_data_reg;

    // Shared compare-and-subtract: every value fed in is below twice the modulus.
    always_comb
    begin
        case (ctrl.op)
            mexp_pkg::OP_RED: cand = {p_reg, sh_reg[WORD_WIDTH-1]};
            mexp_pkg::OP_DBL: cand = {1'b0, p_reg} + {1'b0, p_reg};
            default:          cand = {1'b0, p_reg} + {1'b0, a_reg};
        endcase
        diff = {1'b0, cand} - {2'b00, mod_reg};
        reduced = diff[WORD_WIDTH+1] ? cand[WORD_WIDTH-1:0] : diff[WORD_WIDTH-1:0];
    end

    // Jump condition and next step.
    always_comb
    begin
        case (ctrl.cond)
            mexp_pkg::C_ALWAYS:   take = 1'b1;
            mexp_pkg::C_NO_ITEM:  take = !in_accept;
            mexp_pkg::C_TRIVIAL:  take = (exp_reg == '0) || (mod_reg <= WORD_WIDTH'(1));
            mexp_pkg::C_RED_MORE: take = (cnt_reg != CNT_ONE);
            mexp_pkg::C_DBL_SKIP: take = !sh_reg[WORD_WIDTH-1] && (cnt_reg != CNT_ONE);
            mexp_pkg::C_MUL_MORE: take = (cnt_reg != '0);
            mexp_pkg::C_BASE_MUL: take = !phase_reg && esh_reg[WORD_WIDTH-1];
            mexp_pkg::C_EXP_MORE: take = (ecnt_reg != CNT_ONE);
            mexp_pkg::C_OUT_BUSY: take = !out_free;
            default:              take = 1'b0;
        endcase
        pc_next = take ? ctrl.jump : ctrl.fall;
    end

    // Datapath driven by the control word.
    always_comb
    begin
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        cnt_next       = cnt_reg;
        ecnt_next      = ecnt_reg;
        phase_next     = phase_reg;
        addf_next      = addf_reg;
        sh_next        = sh_reg;
        esh_next       = esh_reg;
        p_next         = p_reg;
        a_next         = a_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !response.ready;

        if (cfg_write)
        begin
            case (cfg_index)
                mexp_pkg::CFG_EXPONENT: exp_next = cfg_data;
                mexp_pkg::CFG_MODULUS:  mod_next = cfg_data;
                default:                exp_next = exp_reg;
            endcase
        end

        case (ctrl.op)
            mexp_pkg::OP_LOAD:
            begin
                if (in_accept)
                begin
                    sh_next  = request.message;
                    p_next   = '0;
                    cnt_next = CNT_FULL;
                    // Trivial cases leave their answer here: one for a zero
                    // exponent, zero for a modulus below two.
                    acc_next = (exp_reg == '0) ? WORD_WIDTH'(1) : '0;
                end
            end
            mexp_pkg::OP_RED:
            begin
                p_next   = reduced;
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg - CNT_ONE;
            end
            mexp_pkg::OP_INIT:
            begin
                base_next = p_reg;
                acc_next  = WORD_WIDTH'(1);
                esh_next  = exp_reg;
                ecnt_next = CNT_FULL;
            end
            mexp_pkg::OP_SQ_START:
            begin
                a_next     = acc_reg;
                sh_next    = acc_reg;
                p_next     = '0;
                cnt_next   = CNT_FULL;
                phase_next = 1'b0;
            end
            mexp_pkg::OP_BASE_START:
            begin
                a_next     = base_reg;
                sh_next    = acc_reg;
                p_next     = '0;
                cnt_next   = CNT_FULL;
                phase_next = 1'b1;
            end
            mexp_pkg::OP_DBL:
            begin
                p_next    = reduced;
                sh_next   = sh_reg << 1;
                cnt_next  = cnt_reg - CNT_ONE;
                addf_next = sh_reg[WORD_WIDTH-1];
            end
            mexp_pkg::OP_ADD:
            begin
                if (addf_reg)
                begin
                    p_next = reduced;
                end
            end
            mexp_pkg::OP_ACC_LOAD:
            begin
                acc_next = p_reg;
            end
            mexp_pkg::OP_EXP_NEXT:
            begin
                esh_next  = esh_reg << 1;
                ecnt_next = ecnt_reg - CNT_ONE;
            end
            mexp_pkg::OP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                end
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg       <= WORD_WIDTH'(mexp_pkg::EXPONENT_RESET);
            mod_reg       <= WORD_WIDTH'(mexp_pkg::MODULUS_RESET);
            pc_reg        <= mexp_pkg::S_WAIT;
            cnt_reg       <= '0;
            ecnt_reg      <= '0;
            phase_reg     <= 1'b0;
            addf_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            exp_reg       <= exp_next;
            mod_reg       <= mod_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            ecnt_reg      <= ecnt_next;
            phase_reg     <= phase_next;
            addf_reg      <= addf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        esh_reg      <= esh_next;
        p_reg        <= p_next;
        a_reg        <= a_next;
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the modular exponentiation block: directed table, then random keys.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = mexp_pkg::WORD_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_AT_RESULT = 45;
    localparam int HOLD_CYCLES = 20_000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 15;
    localparam logic [W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [W-1:0] exponent;
        logic [W-1:0] modulus;
        logic [W-1:0] message;
        logic         known;
        logic [W-1:0] want;
    } vector_t;

    localparam int NUM_VECTORS = 23;
    localparam vector_t VECTORS [0:NUM_VECTORS-1] = '{
        '{32'd29, 32'd91, 32'd0, 1'b1, 32'd0},
        '{32'd29, 32'd91, 32'd1, 1'b1, 32'd1},
        '{32'd29, 32'd91, 32'd91, 1'b1, 32'd0},
        '{32'd29, 32'd91, 32'd2, 1'b0, 32'd0},
        '{32'd29, 32'd91, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{32'd0, 32'd91, 32'd12345, 1'b1, 32'd1},
        '{32'd0, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd1},
        '{32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd1},
        '{32'd5, 32'd1, 32'd7, 1'b1, 32'd0},
        '{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'd7, 32'd0, 32'd3, 1'b1, 32'd0},
        '{32'd1, 32'd1000, 32'd123456, 1'b1, 32'd456},
        '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
        '{32'd2, 32'd2, 32'hFFFF_FFFF, 1'b1, 32'd1},
        '{32'd2, 32'd2, 32'hFFFF_FFFE, 1'b1, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 1'b0, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'd3, 1'b0, 32'd0},
        '{32'd65537, 32'hFFFF_FFFB, 32'hDEAD_BEEF, 1'b0, 32'd0},
        '{32'h8000_0000, 32'hFFFF_FFFB, 32'd5, 1'b0, 32'd0},
        '{32'd3, 32'd10, 32'hAAAA_AAAA, 1'b0, 32'd0},
        '{32'd2, 32'd65536, 32'h5555_FFFF, 1'b0, 32'd0}
    };

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [mexp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [W-1:0]                     cfg_data;

    mexp_msg_if #(.WORD_WIDTH(W)) msg_ch ();
    mexp_res_if #(.WORD_WIDTH(W)) res_ch ();

    modular_exponentiation #(.WORD_WIDTH(W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (msg_ch),
        .response  (res_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [W-1:0] key_exp;
    logic [W-1:0] key_mod;
    logic [W-1:0] expected_power [$];
    int           mismatch_count = 0;
    int           results_seen = 0;
    int           cycle_count = 0;
    int           burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Left-to-right square-and-multiply; 64-bit products never overflow for 32-bit operands.
    function automatic logic [W-1:0] modexp_predict(input logic [W-1:0] e,
                                                    input logic [W-1:0] m,
                                                    input logic [W-1:0] msg);
        logic [63:0] m64;
        logic [63:0] base;
        logic [63:0] acc;
        if (e == '0)
            return W'(1);
        if (m < W'(2))
            return '0;
        m64 = {32'd0, m};
        base = {32'd0, msg} % m64;
        acc = 64'd1;
        for (int i = W - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % m64;
            if (e[i])
                acc = (acc * base) % m64;
        end
        return acc[W-1:0];
    endfunction

    // Both registers are written on back-to-back edges with the enable held high.
    task automatic load_key(input logic [W-1:0] e, input logic [W-1:0] m);
        cfg_write <= 1'b1;
        cfg_index <= mexp_pkg::CFG_EXPONENT;
        cfg_data  <= e;
        @(posedge clk);
        cfg_index <= mexp_pkg::CFG_MODULUS;
        cfg_data  <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
        key_exp = e;
        key_mod = m;
    endtask

    task automatic offer(input logic [W-1:0] msg, input logic known, input logic [W-1:0] want);
        msg_ch.valid   <= 1'b1;
        msg_ch.message <= msg;
        do
            @(posedge clk);
        while (msg_ch.ready !== 1'b1);
        expected_power.push_back(known ? want : modexp_predict(key_exp, key_mod, msg));
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                msg_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        msg_ch.valid <= 1'b0;
        while (expected_power.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [W-1:0] pick_message();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            2: return key_mod;
            3: return key_mod - W'(1);
            4: return W'($urandom_range(0, 15));
            default: return W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [W-1:0] e;
        logic [W-1:0] m;
        msg_ch.valid   <= 1'b0;
        msg_ch.message <= '0;
        cfg_write      <= 1'b0;
        cfg_index      <= mexp_pkg::CFG_EXPONENT;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        key_exp = W'(mexp_pkg::EXPONENT_RESET);
        key_mod = W'(mexp_pkg::MODULUS_RESET);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_VECTORS; i++)
        begin
            if (VECTORS[i].exponent != key_exp || VECTORS[i].modulus != key_mod)
            begin
                drain();
                load_key(VECTORS[i].exponent, VECTORS[i].modulus);
            end
            offer(VECTORS[i].message, VECTORS[i].known, VECTORS[i].want);
            pace();
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            e = W'($urandom);
            m = W'($urandom);
            case (p)
                0: if (m == '0) m = W'(1);
                1: begin e = W'(65537); m[W-1] = 1'b1; end
                2: m = W'($urandom_range(2, 255));
                3: begin e = ALL_ONES; m = ALL_ONES; end
                4: begin e = '0; if (m == '0) m = W'(1); end
                5: m = W'(1);
                6: begin e = W'($urandom_range(1, 16)); if (m < W'(2)) m = W'(2); end
                default: begin m[0] = 1'b0; if (m == '0) m = W'(2); end
            endcase
            load_key(e, m);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                offer(pick_message(), 1'b0, '0);
                pace();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: checks every accepted item and stalls on its own pattern,
    // with one long hold-off so the block fills up and blocks its input.
    initial
    begin
        int           mode;
        int           hold_left;
        int           tick;
        bit           held;
        logic [W-1:0] want;
        res_ch.ready <= 1'b0;
        mode = 0;
        hold_left = 0;
        tick = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                results_seen++;
                if (expected_power.size() == 0)
                begin
                    $error("power_result: expected none, actual %h", res_ch.power_result);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_power.pop_front();
                    if (res_ch.power_result !== want)
                    begin
                        $error("power_result: expected %h, actual %h", want,
                               res_ch.power_result);
                        mismatch_count++;
                    end
                end
            end
            if (!held && results_seen >= HOLD_AT_RESULT)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            tick++;
            if (tick % 64 == 0)
                mode = $urandom_range(0, 2);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    default: res_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

endmodule
